### sv/blr_pkg.sv
// ----------------------------------------------------------------------------
// Line rasterizer package
// Shared constants, request codes and control structs of the line rasterizer.
// ----------------------------------------------------------------------------
package blr_pkg;

    localparam int COORD_BITS_DEF = 10;
    localparam int COLOR_BITS     = 8;
    localparam int RGB_BITS       = 3 * COLOR_BITS;

    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        OCT_X_RISE = 2'd0,
        OCT_Y_RISE = 2'd1,
        OCT_X_FALL = 2'd2,
        OCT_Y_FALL = 2'd3
    } t_octant;

    typedef struct packed {
        logic fire;
        t_op  op;
    } t_eng_req;

    typedef struct packed {
        logic emit;
        logic last;
    } t_eng_rsp;

endpackage

### sv/blr_engine.sv
// ----------------------------------------------------------------------------
// Line rasterizer engine
// Holds the line state and computes the next pixel for one request per cycle.
// ----------------------------------------------------------------------------
module blr_engine #(
    parameter int COORD_BITS = blr_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  blr_pkg::t_eng_req            i_req,
    input  logic [COORD_BITS-1:0]        i_start_x,
    input  logic [COORD_BITS-1:0]        i_start_y,
    input  logic [COORD_BITS-1:0]        i_end_x,
    input  logic [COORD_BITS-1:0]        i_end_y,
    input  logic [blr_pkg::RGB_BITS-1:0] i_color,
    output blr_pkg::t_eng_rsp            o_rsp,
    output logic [COORD_BITS-1:0]        o_pixel_x,
    output logic [COORD_BITS-1:0]        o_pixel_y,
    output logic [blr_pkg::RGB_BITS-1:0] o_color
);
    import blr_pkg::*;

    localparam int EW = COORD_BITS + 2;
    localparam int SW = COORD_BITS + 3;

    logic                    r_active;
    t_octant                 r_oct;
    logic [COORD_BITS-1:0]   r_major;
    logic [COORD_BITS-1:0]   r_minor;
    logic [COORD_BITS-1:0]   r_major_end;
    logic signed [EW-1:0]    r_err;
    logic [COORD_BITS:0]     r_inc;
    logic [COORD_BITS-1:0]   r_delta;
    logic [RGB_BITS-1:0]     r_color;

    logic                    swap;
    logic [COORD_BITS-1:0]   x1, y1, x2, y2, dx, dy;
    logic                    rising, zero_len, x_major;

    logic [COORD_BITS-1:0]   major_nxt, minor_nxt;
    logic signed [SW-1:0]    s_sum, s_delta, s_adj;
    logic                    over, last;
    logic signed [EW-1:0]    err_nxt;

    always_comb begin
        swap     = i_end_x < i_start_x;
        x1       = swap ? i_end_x : i_start_x;
        y1       = swap ? i_end_y : i_start_y;
        x2       = swap ? i_start_x : i_end_x;
        y2       = swap ? i_start_y : i_end_y;
        dx       = x2 - x1;
        rising   = y2 >= y1;
        dy       = rising ? (y2 - y1) : (y1 - y2);
        zero_len = (dx == '0) && (dy == '0);
        x_major  = dx >= dy;
    end

    always_comb begin
        major_nxt = (r_oct == OCT_Y_FALL) ? (r_major - 1'b1) : (r_major + 1'b1);
        s_sum     = SW'(r_err) + SW'({1'b0, r_inc});
        s_delta   = SW'({1'b0, r_delta});
        s_adj     = s_sum - SW'({r_delta, 1'b0});
        over      = s_sum > s_delta;
        err_nxt   = over ? EW'(s_adj) : EW'(s_sum);
        if (over) begin
            minor_nxt = (r_oct == OCT_X_FALL) ? (r_minor - 1'b1) : (r_minor + 1'b1);
        end else begin
            minor_nxt = r_minor;
        end
        last = major_nxt == r_major_end;
    end

    always_comb begin
        o_rsp     = '0;
        o_pixel_x = x1;
        o_pixel_y = y1;
        o_color   = i_color;
        if (i_req.op == OP_START) begin
            o_rsp.emit = i_req.fire && !zero_len;
        end else begin
            o_rsp.emit = i_req.fire && r_active;
            o_rsp.last = last;
            o_color    = r_color;
            if (r_oct == OCT_X_RISE || r_oct == OCT_X_FALL) begin
                o_pixel_x = major_nxt;
                o_pixel_y = minor_nxt;
            end else begin
                o_pixel_x = minor_nxt;
                o_pixel_y = major_nxt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_oct    <= OCT_X_RISE;
        end else if (i_req.fire) begin
            if (i_req.op == OP_START) begin
                r_active <= !zero_len;
                if (!zero_len) begin
                    r_color <= i_color;
                    r_err   <= '0;
                    if (x_major) begin
                        r_oct       <= rising ? OCT_X_RISE : OCT_X_FALL;
                        r_major     <= x1;
                        r_minor     <= y1;
                        r_major_end <= x2;
                        r_delta     <= dx;
                        r_inc       <= {dy, 1'b0};
                    end else begin
                        r_oct       <= rising ? OCT_Y_RISE : OCT_Y_FALL;
                        r_major     <= y1;
                        r_minor     <= x1;
                        r_major_end <= y2;
                        r_delta     <= dy;
                        r_inc       <= {dx, 1'b0};
                    end
                end
            end else if (r_active) begin
                r_major  <= major_nxt;
                r_minor  <= minor_nxt;
                r_err    <= err_nxt;
                r_active <= !last;
            end
        end
    end

endmodule

### sv/bresenham_line_rasterizer_core.sv
// Each request passes the input register, the engine and then the output register.
// One request per cycle unless the output stalls; each step adds, subtracts and compares.
// Reset is synchronous and active low; it empties both register stages and drops any line.
// A start request with equal endpoints and a step request with no line produce no pixel.
// ----------------------------------------------------------------------------
// Line rasterizer core
// Input register, line engine and output register with valid and ready flow.
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer_core #(
    parameter int COORD_BITS = blr_pkg::COORD_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_operation,
    input  logic [COORD_BITS-1:0]          i_start_x,
    input  logic [COORD_BITS-1:0]          i_start_y,
    input  logic [COORD_BITS-1:0]          i_end_x,
    input  logic [COORD_BITS-1:0]          i_end_y,
    input  logic [blr_pkg::COLOR_BITS-1:0] i_color_red,
    input  logic [blr_pkg::COLOR_BITS-1:0] i_color_green,
    input  logic [blr_pkg::COLOR_BITS-1:0] i_color_blue,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [COORD_BITS-1:0]          o_pixel_x,
    output logic [COORD_BITS-1:0]          o_pixel_y,
    output logic [blr_pkg::COLOR_BITS-1:0] o_pixel_red,
    output logic [blr_pkg::COLOR_BITS-1:0] o_pixel_green,
    output logic [blr_pkg::COLOR_BITS-1:0] o_pixel_blue,
    output logic                           o_last_pixel
);
    import blr_pkg::*;

    logic                  r_in_valid;
    t_op                   r_op;
    logic [COORD_BITS-1:0] r_sx, r_sy, r_ex, r_ey;
    logic [RGB_BITS-1:0]   r_in_color;

    logic                  r_out_valid;
    logic [COORD_BITS-1:0] r_px, r_py;
    logic [RGB_BITS-1:0]   r_out_color;
    logic                  r_last;

    logic                  adv;
    t_eng_req              req;
    t_eng_rsp              rsp;
    logic [COORD_BITS-1:0] eng_px, eng_py;
    logic [RGB_BITS-1:0]   eng_color;

    assign adv        = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || adv;
    assign req.fire   = r_in_valid && adv;
    assign req.op     = r_op;

    blr_engine #(
        .COORD_BITS(COORD_BITS)
    ) u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req),
        .i_start_x (r_sx),
        .i_start_y (r_sy),
        .i_end_x   (r_ex),
        .i_end_y   (r_ey),
        .i_color   (r_in_color),
        .o_rsp     (rsp),
        .o_pixel_x (eng_px),
        .o_pixel_y (eng_py),
        .o_color   (eng_color)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (i_in_valid && o_in_ready) begin
            r_op       <= t_op'(i_operation);
            r_sx       <= i_start_x;
            r_sy       <= i_start_y;
            r_ex       <= i_end_x;
            r_ey       <= i_end_y;
            r_in_color <= {i_color_red, i_color_green, i_color_blue};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= req.fire && rsp.emit;
        end
        if (req.fire && rsp.emit) begin
            r_px        <= eng_px;
            r_py        <= eng_py;
            r_out_color <= eng_color;
            r_last      <= rsp.last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_x     = r_px;
    assign o_pixel_y     = r_py;
    assign o_pixel_red   = r_out_color[RGB_BITS-1 -: COLOR_BITS];
    assign o_pixel_green = r_out_color[COLOR_BITS +: COLOR_BITS];
    assign o_pixel_blue  = r_out_color[COLOR_BITS-1:0];
    assign o_last_pixel  = r_last;

endmodule

### sv/blr_checker.sv
// ----------------------------------------------------------------------------
// Line rasterizer checker
// Port level assertions on the rasterizer core, attached by a bind statement.
// ----------------------------------------------------------------------------
module blr_checker #(
    parameter int COORD_BITS = blr_pkg::COORD_BITS_DEF
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input logic                           i_operation,
    input logic [COORD_BITS-1:0]          i_start_x,
    input logic [COORD_BITS-1:0]          i_start_y,
    input logic [COORD_BITS-1:0]          i_end_x,
    input logic [COORD_BITS-1:0]          i_end_y,
    input logic [blr_pkg::COLOR_BITS-1:0] i_color_red,
    input logic [blr_pkg::COLOR_BITS-1:0] i_color_green,
    input logic [blr_pkg::COLOR_BITS-1:0] i_color_blue,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input logic [COORD_BITS-1:0]          o_pixel_x,
    input logic [COORD_BITS-1:0]          o_pixel_y,
    input logic [blr_pkg::COLOR_BITS-1:0] o_pixel_red,
    input logic [blr_pkg::COLOR_BITS-1:0] o_pixel_green,
    input logic [blr_pkg::COLOR_BITS-1:0] o_pixel_blue,
    input logic                           o_last_pixel
);

    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Output valid after reset.");

    a_stall_holds_ready : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready && !o_in_ready |=> o_in_ready == i_out_ready)
        else $error("Input side freed while the full pipeline was stalled.");

    a_valid_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("Pending pixel dropped.");

    a_payload_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_pixel_x) && $stable(o_pixel_y) && $stable(o_pixel_red) &&
            $stable(o_pixel_green) && $stable(o_pixel_blue) && $stable(o_last_pixel))
        else $error("Pending pixel changed.");

    a_request_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=>
            i_in_valid && $stable(i_operation) && $stable(i_start_x) &&
            $stable(i_start_y) && $stable(i_end_x) && $stable(i_end_y) &&
            $stable(i_color_red) && $stable(i_color_green) && $stable(i_color_blue))
        else $error("Waiting request changed.");

endmodule

bind bresenham_line_rasterizer_core blr_checker #(
    .COORD_BITS(COORD_BITS)
) u_blr_checker (.*);
